FILE: rtl/tpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_pkg: shared types and constants of the turtle plotter
// Grid geometry, command codes, headings, state encoding and the grid memory
// request bundle.
// ----------------------------------------------------------------------------
package tpb_pkg;

  localparam int GRID_SIZE = 64;
  localparam int START_POS = 20;

  // Fixed field widths
  localparam int COORD_W = 6;
  localparam int DIST_W  = 6;
  localparam int CMD_W   = 3;
  localparam int ROW_W   = 64;

  localparam int IDX_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  localparam logic [COORD_W-1:0] MAX_C = COORD_W'(GRID_SIZE - 1);
  localparam logic [COORD_W-1:0] START_C =
    (START_POS > GRID_SIZE - 1) ? COORD_W'(GRID_SIZE - 1) : COORD_W'(START_POS);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_SIZE - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PEN_UP   = 3'd0,
    CMD_PEN_DOWN = 3'd1,
    CMD_TURN_R   = 3'd2,
    CMD_TURN_L   = 3'd3,
    CMD_MOVE     = 3'd4,
    CMD_READ     = 3'd5
  } tpb_cmd_t;

  typedef enum logic [1:0] {
    HEAD_XP = 2'd0,
    HEAD_YM = 2'd1,
    HEAD_XM = 2'd2,
    HEAD_YP = 2'd3
  } tpb_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_MARK,
    ST_READ
  } tpb_state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [GRID_SIZE-1:0] wr_data;
  } tpb_mem_req_t;

endpackage

FILE: rtl/tpb_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_grid: row store of the plot grid
// One-write one-read synchronous memory, one row per entry, with a valid bit
// per row so that an unwritten row reads as cleared right after reset.
// ----------------------------------------------------------------------------
module tpb_grid (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpb_pkg::tpb_mem_req_t          req,
  output logic [tpb_pkg::GRID_SIZE-1:0]  rd_data
);

  logic [tpb_pkg::GRID_SIZE-1:0] mem_r [tpb_pkg::GRID_SIZE];
  logic [tpb_pkg::GRID_SIZE-1:0] valid_r;
  logic [tpb_pkg::GRID_SIZE-1:0] rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  // Track written rows; reset clears them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: rtl/turtle_plotter_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_plotter_bitmap: turtle plotter over a square bit grid
// Keeps a position, heading and pen state, marks cells in a row memory as
// the turtle moves with the pen down, and reads the grid out row by row.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low; for a
// move or readout busy then stays high until the block can take the next
// one. Pen and turn commands and a move of zero cells finish as they are
// taken, with busy left low. A move runs one ST_STEP per cell with the pen
// lifted, and ST_STEP then ST_MARK per cell with the pen down, since ST_STEP
// reads the row under the new position from the grid memory and ST_MARK
// writes it back the cycle after (one memory access per cycle). A readout
// issues one row read per cycle and emits GRID_SIZE beats on consecutive
// cycles, each from the registered read of its row; busy drops as the last
// beat shows. Each beat stands on out_* for exactly one cycle with out_strobe
// high and must be taken then: there is no way to stall the output. The grid
// is clear right after reset with no clearing pass; a per-row valid bit
// masks rows not yet written. Codes 6 and 7 are dropped without a result.
// ----------------------------------------------------------------------------
module turtle_plotter_bitmap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tpb_pkg::CMD_W-1:0]     in_req_type,
  input  logic [tpb_pkg::DIST_W-1:0]    in_distance,
  output logic                          out_strobe,
  output logic [tpb_pkg::ROW_W-1:0]     out_row_bits,
  output logic [tpb_pkg::COORD_W-1:0]   out_row_index,
  output logic                          out_last_row
);

  // Control state
  tpb_pkg::tpb_state_t            state_r, state_nxt;
  logic [tpb_pkg::COORD_W-1:0]    pos_x_r, pos_x_nxt;
  logic [tpb_pkg::COORD_W-1:0]    pos_y_r, pos_y_nxt;
  logic [1:0]                     heading_r, heading_nxt;
  logic                           pen_r, pen_nxt;
  logic [tpb_pkg::DIST_W-1:0]     cnt_r, cnt_nxt;
  logic [tpb_pkg::IDX_W-1:0]      row_r, row_nxt;

  // Readout beat tracking, registered in step with the memory read data
  logic                           ro_pend_r, ro_pend_nxt;
  logic [tpb_pkg::COORD_W-1:0]    ro_idx_r, ro_idx_nxt;
  logic                           ro_last_r, ro_last_nxt;

  // Next position after one step, saturated at both edges
  logic [tpb_pkg::COORD_W-1:0]    step_x, step_y;

  tpb_pkg::tpb_mem_req_t          mem_req;
  logic [tpb_pkg::GRID_SIZE-1:0]  mem_rd_data;

  tpb_grid u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Step one cell along the heading; hold the coordinate at an edge
  always_comb begin
    step_x = pos_x_r;
    step_y = pos_y_r;
    unique case (tpb_pkg::tpb_head_t'(heading_r))
      tpb_pkg::HEAD_XP: begin
        if (pos_x_r < tpb_pkg::MAX_C) step_x = pos_x_r + 1'b1;
      end
      tpb_pkg::HEAD_YM: begin
        if (pos_y_r != '0) step_y = pos_y_r - 1'b1;
      end
      tpb_pkg::HEAD_XM: begin
        if (pos_x_r != '0) step_x = pos_x_r - 1'b1;
      end
      tpb_pkg::HEAD_YP: begin
        if (pos_y_r < tpb_pkg::MAX_C) step_y = pos_y_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tpb_pkg::ST_IDLE;
      pos_x_r   <= tpb_pkg::START_C;
      pos_y_r   <= tpb_pkg::START_C;
      heading_r <= tpb_pkg::HEAD_XP;
      pen_r     <= 1'b0;
      cnt_r     <= '0;
      row_r     <= '0;
      ro_pend_r <= 1'b0;
      ro_idx_r  <= '0;
      ro_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      heading_r <= heading_nxt;
      pen_r     <= pen_nxt;
      cnt_r     <= cnt_nxt;
      row_r     <= row_nxt;
      ro_pend_r <= ro_pend_nxt;
      ro_idx_r  <= ro_idx_nxt;
      ro_last_r <= ro_last_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    heading_nxt = heading_r;
    pen_nxt     = pen_r;
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    ro_pend_nxt = 1'b0;
    ro_idx_nxt  = ro_idx_r;
    ro_last_nxt = 1'b0;
    mem_req     = '0;

    unique case (state_r)
      tpb_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tpb_pkg::tpb_cmd_t'(in_req_type))
            tpb_pkg::CMD_PEN_UP:   pen_nxt = 1'b0;
            tpb_pkg::CMD_PEN_DOWN: pen_nxt = 1'b1;
            tpb_pkg::CMD_TURN_R:   heading_nxt = heading_r - 1'b1;
            tpb_pkg::CMD_TURN_L:   heading_nxt = heading_r + 1'b1;
            tpb_pkg::CMD_MOVE: begin
              // Zero distance leaves everything as it is
              cnt_nxt = in_distance;
              if (in_distance != '0) state_nxt = tpb_pkg::ST_STEP;
            end
            tpb_pkg::CMD_READ: begin
              row_nxt   = '0;
              state_nxt = tpb_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end

      tpb_pkg::ST_STEP: begin
        // Advance one cell; with the pen down fetch the row under it
        pos_x_nxt = step_x;
        pos_y_nxt = step_y;
        cnt_nxt   = cnt_r - 1'b1;
        if (pen_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = step_y[tpb_pkg::IDX_W-1:0];
          state_nxt       = tpb_pkg::ST_MARK;
        end else if (cnt_r == tpb_pkg::DIST_W'(1)) begin
          state_nxt = tpb_pkg::ST_IDLE;
        end
      end

      tpb_pkg::ST_MARK: begin
        // Set the bit of the current column and write the row back
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_y_r[tpb_pkg::IDX_W-1:0];
        mem_req.wr_data = mem_rd_data |
                          (tpb_pkg::GRID_SIZE'(1) << pos_x_r[tpb_pkg::IDX_W-1:0]);
        state_nxt       = (cnt_r == '0) ? tpb_pkg::ST_IDLE : tpb_pkg::ST_STEP;
      end

      tpb_pkg::ST_READ: begin
        // Issue one row read per cycle; the beat goes out next cycle
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = row_r;
        ro_pend_nxt     = 1'b1;
        ro_idx_nxt      = tpb_pkg::COORD_W'(row_r);
        ro_last_nxt     = (row_r == tpb_pkg::LAST_ROW);
        row_nxt         = row_r + 1'b1;
        if (row_r == tpb_pkg::LAST_ROW) state_nxt = tpb_pkg::ST_IDLE;
      end

      default: state_nxt = tpb_pkg::ST_IDLE;
    endcase
  end

  assign busy          = (state_r != tpb_pkg::ST_IDLE);
  assign out_strobe    = ro_pend_r;
  assign out_row_bits  = tpb_pkg::ROW_W'(mem_rd_data);
  assign out_row_index = ro_idx_r;
  assign out_last_row  = ro_last_r;

endmodule

FILE: rtl/tpb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_checker: port-level checks of the turtle plotter
// Watches the readout beat sequence and the busy handshake.
// ----------------------------------------------------------------------------
module tpb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [tpb_pkg::CMD_W-1:0]     in_req_type,
  input logic                          out_strobe,
  input logic [tpb_pkg::COORD_W-1:0]   out_row_index,
  input logic                          out_last_row
);

  // A readout opens on row zero
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> out_row_index == '0)
    else $error("readout did not start at row zero");

  // Rows follow back to back with increasing index until the last one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_row |=>
      out_strobe && out_row_index == $past(out_row_index) + 1'b1)
    else $error("readout beats not consecutive");

  // Last flag marks exactly the final row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_last_row == (out_row_index == tpb_pkg::COORD_W'(tpb_pkg::GRID_SIZE - 1)))
    else $error("last row flag misplaced");

  // Block stays busy while a readout still has rows to send
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_row |-> busy)
    else $error("busy dropped during readout");

  // A taken readout command raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == tpb_pkg::CMD_READ |=> busy)
    else $error("readout command did not raise busy");

endmodule

bind turtle_plotter_bitmap tpb_checker u_tpb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_req_type   (in_req_type),
  .out_strobe    (out_strobe),
  .out_row_index (out_row_index),
  .out_last_row  (out_last_row)
);

FILE: dv/tb_turtle_plotter_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turtle_plotter_bitmap: self-checking bench for the turtle plotter
// Feeds pen, turn, move and readout commands through the start/busy port and
// keeps a plotter model of its own (grid, position, heading, pen). Every
// readout beat is checked field by field against the rows the model expects.
// ----------------------------------------------------------------------------
module tb_turtle_plotter_bitmap;
  import tpb_pkg::*;

  // Reserved command codes: the block must drop them without a result
  localparam logic [CMD_W-1:0] CODE_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CODE_RSVD_B = 3'd7;

  // Run limit: far above the slowest legal run (204 commands, each at most
  // a full-range move with the pen down or a readout, plus sender gaps)
  localparam int LIMIT_CYCLES = 400000;
  // Quiet time after the last beat: longer than the slowest command
  localparam int TAIL_CYCLES  = 2 * GRID_SIZE + 16;

  typedef struct packed {
    logic [CMD_W-1:0]  req;
    logic [DIST_W-1:0] dist_cells;
  } plot_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]   bits;
    logic [COORD_W-1:0] index;
    logic               last;
  } row_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_req_type = '0;
  logic [DIST_W-1:0]   in_distance = '0;
  logic                out_strobe;
  logic [ROW_W-1:0]    out_row_bits;
  logic [COORD_W-1:0]  out_row_index;
  logic                out_last_row;

  turtle_plotter_bitmap DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_distance   (in_distance),
    .out_strobe    (out_strobe),
    .out_row_bits  (out_row_bits),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Plotter model: own copy of grid, position, heading and pen
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]   grid_model [GRID_SIZE];
  logic [COORD_W-1:0] turtle_x;
  logic [COORD_W-1:0] turtle_y;
  tpb_head_t          turtle_head;
  logic               pen_down;
  row_beat_t          row_expect_q [$];

  task automatic plotter_reset();
    for (int r = 0; r < GRID_SIZE; r++) grid_model[r] = '0;
    turtle_x    = START_C;
    turtle_y    = START_C;
    turtle_head = HEAD_XP;
    pen_down    = 1'b0;
    row_expect_q.delete();
  endtask

  // Apply one accepted command; a readout queues the rows it must produce
  task automatic plot_apply(input logic [CMD_W-1:0] req,
                            input logic [DIST_W-1:0] dist_cells);
    row_beat_t beat;
    case (req)
      CMD_PEN_UP:   pen_down = 1'b0;
      CMD_PEN_DOWN: pen_down = 1'b1;
      // Right is one quarter turn back, left one forward, both wrap mod 4
      CMD_TURN_R:   turtle_head = tpb_head_t'(turtle_head - 2'd1);
      CMD_TURN_L:   turtle_head = tpb_head_t'(turtle_head + 2'd1);
      CMD_MOVE: begin
        // Step cell by cell, saturating at the edges; the starting cell is
        // not marked, but an edge cell gets marked again on every step
        for (int i = 0; i < dist_cells; i++) begin
          case (turtle_head)
            HEAD_XP: if (turtle_x != MAX_C) turtle_x = turtle_x + 1'b1;
            HEAD_YM: if (turtle_y != '0)    turtle_y = turtle_y - 1'b1;
            HEAD_XM: if (turtle_x != '0)    turtle_x = turtle_x - 1'b1;
            HEAD_YP: if (turtle_y != MAX_C) turtle_y = turtle_y + 1'b1;
          endcase
          if (pen_down) grid_model[turtle_y][turtle_x] = 1'b1;
        end
      end
      CMD_READ: begin
        for (int r = 0; r < GRID_SIZE; r++) begin
          beat.bits  = grid_model[r];
          beat.index = COORD_W'(r);
          beat.last  = (r == GRID_SIZE - 1);
          row_expect_q.push_back(beat);
        end
      end
      default: ;  // reserved codes: drop
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Command driver: presents the head of cmd_q at the falling edge and holds
  // it until the block takes it; random gaps between commands
  // --------------------------------------------------------------------------
  plot_cmd_t cmd_q [$];
  int        sender_idle_pct = 11;
  bit        driving = 1'b0;
  int        issued_cnt = 0;
  int        accepted_cnt = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // Drop the command the block took at the last rising edge
      if (driving && accepted_cnt == issued_cnt) begin
        void'(cmd_q.pop_front());
        driving = 1'b0;
      end
      // Present the next command unless this cycle is an idle one; a
      // back-to-back command keeps start high with a single assignment
      if (!driving && cmd_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        driving = 1'b1;
        issued_cnt++;
        in_req_type <= cmd_q[0].req;
        in_distance <= cmd_q[0].dist_cells;
      end
      start <= driving;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: count accepted commands into the model, check readout beats
  // --------------------------------------------------------------------------
  int mismatch_count = 0;

  always @(posedge clk) begin : row_check
    row_beat_t want;
    if (rst_n) begin
      if (start && !busy) begin
        accepted_cnt++;
        plot_apply(in_req_type, in_distance);
      end
      if (out_strobe) begin
        if (row_expect_q.size() == 0) begin
          $error("unexpected row beat: index %0d bits %h", out_row_index, out_row_bits);
          mismatch_count++;
        end else begin
          want = row_expect_q.pop_front();
          if (out_row_bits !== want.bits) begin
            $error("row_bits: expected %h, got %h", want.bits, out_row_bits);
            mismatch_count++;
          end
          if (out_row_index !== want.index) begin
            $error("row_index: expected %0d, got %0d", want.index, out_row_index);
            mismatch_count++;
          end
          if (out_last_row !== want.last) begin
            $error("last_row: expected %0b, got %0b", want.last, out_last_row);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Hard stop if the block hangs
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_cmd(input logic [CMD_W-1:0] req,
                         input logic [DIST_W-1:0] dist_cells);
    plot_cmd_t c;
    c.req        = req;
    c.dist_cells = dist_cells;
    cmd_q.push_back(c);
  endtask

  // Moves, mostly short, are the commonest pick and pen down outweighs pen up
  // so the drawing grows; the odd readout, reserved code and full-range distance
  task automatic add_random_cmds(input int count);
    int pick;
    logic [DIST_W-1:0] d;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      d = ($urandom_range(3) == 0) ? DIST_W'($urandom_range(63)) : DIST_W'($urandom_range(12));
      if (pick < 8)       add_cmd(CMD_READ, DIST_W'($urandom_range(63)));
      else if (pick < 45) add_cmd(CMD_MOVE, d);
      else if (pick < 60) add_cmd(CMD_PEN_DOWN, DIST_W'($urandom_range(63)));
      else if (pick < 68) add_cmd(CMD_PEN_UP, DIST_W'($urandom_range(63)));
      else if (pick < 80) add_cmd(CMD_TURN_R, DIST_W'($urandom_range(63)));
      else if (pick < 92) add_cmd(CMD_TURN_L, DIST_W'($urandom_range(63)));
      else if (pick < 96) add_cmd(CODE_RSVD_A, DIST_W'($urandom_range(63)));
      else                add_cmd(CODE_RSVD_B, DIST_W'($urandom_range(63)));
    end
  endtask

  // Hold until every queued command is taken and every row has come back
  task automatic drain();
    while (cmd_q.size() > 0 || driving || row_expect_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    plotter_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty grid, reserved codes, zero and full moves that run
    // into every edge in all four headings, turn wrap, pen-up travel
    sender_idle_pct = 11;
    add_cmd(CMD_READ, 6'd0);
    add_cmd(CODE_RSVD_A, 6'd63);
    add_cmd(CODE_RSVD_B, 6'd0);
    add_cmd(CMD_PEN_DOWN, 6'd0);
    add_cmd(CMD_MOVE, 6'd0);
    add_cmd(CMD_MOVE, 6'd63);
    add_cmd(CMD_TURN_R, 6'd0);
    add_cmd(CMD_MOVE, 6'd63);
    add_cmd(CMD_TURN_R, 6'd63);
    add_cmd(CMD_MOVE, 6'd63);
    add_cmd(CMD_TURN_R, 6'd0);
    add_cmd(CMD_MOVE, 6'd63);
    add_cmd(CMD_READ, 6'd63);
    repeat (4) add_cmd(CMD_TURN_L, 6'd0);
    add_cmd(CMD_TURN_L, 6'd63);
    add_cmd(CMD_PEN_UP, 6'd63);
    add_cmd(CMD_MOVE, 6'd5);
    add_cmd(CMD_PEN_DOWN, 6'd0);
    add_cmd(CMD_MOVE, 6'd1);
    add_cmd(CMD_READ, 6'd0);
    drain();

    // Random: light sender gaps, then heavy gaps, then back-to-back
    add_random_cmds(60);
    drain();
    sender_idle_pct = 57;
    add_random_cmds(60);
    drain();
    sender_idle_pct = 0;
    add_random_cmds(60);
    add_cmd(CMD_READ, 6'd0);
    drain();

    // Let any trailing move finish; a stray beat here is still caught
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tpb_pkg.sv
rtl/tpb_grid.sv
rtl/turtle_plotter_bitmap.sv
rtl/tpb_checker.sv
dv/tb_turtle_plotter_bitmap.sv
